### rtl/core/hnorm_pkg.sv
`default_nettype none

package hnorm_pkg;

    localparam int LEVEL_BITS = 16;

    typedef logic signed [LEVEL_BITS-1:0] level_t;

    localparam level_t LEVEL_MAX = level_t'({1'b0, {(LEVEL_BITS-1){1'b1}}});
    localparam level_t LEVEL_MIN = level_t'({1'b1, {(LEVEL_BITS-1){1'b0}}});
    localparam level_t LEVEL_ONE = level_t'(1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

endpackage

`default_nettype wire

### rtl/core/html_text_normalizer_top.sv
// Channel | Handshake             | Payload
// input   | byte_valid/byte_ready | in_byte, end_of_text
// result  | res_valid/res_ready   | out_byte, out_valid, out_last
//
// One item per cycle while the queue has room: a byte is registered,
// decoded and its zero to two results are pushed into a 3-entry result queue.
// The decode stage advances while the queue holds at most one result, so
// an item giving two results holds the input back until a result leaves, and a
// stalled result side stalls the input once two results wait.
// byte_ready depends only on registered state.
// Reset clears the tag state, the input stage and the queue.
`default_nettype none

module html_text_normalizer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    output logic            out_last
);

    localparam int QDEPTH  = 3;
    localparam int MAX_RES = 2;
    localparam int CNT_W   = $clog2(QDEPTH + 1);

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eot_reg;
    logic       s1_fire;

    // parser state
    hnorm_pkg::level_t level_reg, level_next;
    logic seen_reg, seen_next;
    logic quote_reg, quote_next;
    logic held_reg, held_next;
    logic peq_reg, peq_next;

    // result queue
    hnorm_pkg::result_t q_reg  [QDEPTH];
    hnorm_pkg::result_t q_next [QDEPTH];
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;
    logic [CNT_W-1:0]   base;

    // decode results
    hnorm_pkg::result_t r0, r1;
    logic [1:0]         nres;

    hnorm_pkg::level_t lvl_inc, lvl_dec;
    logic              lvl_is1;
    logic              flush, emit_b, eot_space, conv;
    logic [7:0]        b;
    logic [7:0]        c;

    assign s1_fire    = s1_valid_reg && (cnt_reg <= CNT_W'(QDEPTH - MAX_RES));
    assign byte_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_eot_reg  <= end_of_text;
        end
    end

    assign c       = s1_byte_reg;
    assign lvl_is1 = (level_reg == hnorm_pkg::LEVEL_ONE);
    assign lvl_inc = (level_reg == hnorm_pkg::LEVEL_MAX) ? level_reg
                                                         : level_reg + hnorm_pkg::LEVEL_ONE;
    assign lvl_dec = (level_reg == hnorm_pkg::LEVEL_MIN) ? level_reg
                                                         : level_reg - hnorm_pkg::LEVEL_ONE;

    always_comb
    begin
        level_next = level_reg;
        seen_next  = seen_reg;
        quote_next = quote_reg;
        held_next  = held_reg;
        peq_next   = peq_reg;
        flush      = 1'b0;
        emit_b     = 1'b0;
        b          = c;
        conv       = 1'b0;

        if (c == hnorm_pkg::CH_LT)
        begin
            flush      = held_reg;
            emit_b     = 1'b1;
            level_next = lvl_inc;
            held_next  = 1'b0;
            if (lvl_inc == hnorm_pkg::LEVEL_ONE)
            begin
                seen_next = 1'b1;
            end
        end
        else if (c == hnorm_pkg::CH_EQ && lvl_is1)
        begin
            emit_b    = 1'b1;
            held_next = 1'b0;
            seen_next = 1'b1;
        end
        else if (hnorm_pkg::is_ws(c))
        begin
            if (!seen_reg)
            begin
                held_next = 1'b1;
                seen_next = 1'b1;
                peq_next  = 1'b0;
            end
        end
        else if (c == hnorm_pkg::CH_GT)
        begin
            flush      = !lvl_is1 && held_reg;
            emit_b     = 1'b1;
            held_next  = 1'b0;
            level_next = lvl_dec;
        end
        else if (c == hnorm_pkg::CH_SQ && lvl_is1)
        begin
            conv      = quote_reg || (!held_reg && peq_reg);
            flush     = held_reg;
            emit_b    = 1'b1;
            held_next = 1'b0;
            b         = conv ? hnorm_pkg::CH_DQ : hnorm_pkg::CH_SQ;
            if (conv)
            begin
                quote_next = !quote_reg;
            end
        end
        else
        begin
            flush     = held_reg;
            emit_b    = 1'b1;
            held_next = 1'b0;
            seen_next = 1'b0;
            b         = hnorm_pkg::is_upper(c) ? c + hnorm_pkg::CASE_OFS : c;
        end

        if (emit_b)
        begin
            peq_next = (b == hnorm_pkg::CH_EQ);
        end

        eot_space = s1_eot_reg && held_next;

        r0.data  = flush ? hnorm_pkg::CH_SP : (emit_b ? b : (eot_space ? hnorm_pkg::CH_SP : 8'h00));
        r0.valid = flush || emit_b || eot_space;
        r0.last  = s1_eot_reg && !(flush && emit_b);
        r1.data  = b;
        r1.valid = 1'b1;
        r1.last  = s1_eot_reg;

        if (flush && emit_b)
        begin
            nres = 2'd2;
        end
        else if (r0.valid || s1_eot_reg)
        begin
            nres = 2'd1;
        end
        else
        begin
            nres = 2'd0;
        end

        if (s1_eot_reg)
        begin
            level_next = '0;
            seen_next  = 1'b0;
            quote_next = 1'b0;
            held_next  = 1'b0;
            peq_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            seen_reg  <= 1'b0;
            quote_reg <= 1'b0;
            held_reg  <= 1'b0;
            peq_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            level_reg <= level_next;
            seen_reg  <= seen_next;
            quote_reg <= quote_next;
            held_reg  <= held_next;
            peq_reg   <= peq_next;
        end
    end

    assign res_valid = (cnt_reg != '0);
    assign pop       = res_valid && res_ready;
    assign out_byte  = q_reg[0].data;
    assign out_valid = q_reg[0].valid;
    assign out_last  = q_reg[0].last;
    assign base      = cnt_reg - CNT_W'(pop);

    always_comb
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            if (CNT_W'(i) < base)
            begin
                if (pop)
                begin
                    q_next[i] = q_reg[(i < QDEPTH - 1) ? i + 1 : i];
                end
            end
            else if (s1_fire && CNT_W'(i) == base && nres != 2'd0)
            begin
                q_next[i] = r0;
            end
            else if (s1_fire && CNT_W'(i) == base + 1'b1 && nres == 2'd2)
            begin
                q_next[i] = r1;
            end
        end
        cnt_next = base + (s1_fire ? CNT_W'(nres) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire

### rtl/core/html_text_normalizer_checker.sv
`default_nettype none

module html_text_normalizer_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       byte_valid,
    input wire logic       byte_ready,
    input wire logic [7:0] in_byte,
    input wire logic       end_of_text,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_valid,
    input wire logic       out_last
);

    // a stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(in_byte)
            && $stable(end_of_text))
        else $error("input item changed while stalled");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_byte)
            && $stable(out_valid) && $stable(out_last))
        else $error("result changed while stalled");

    // a bare end marker is always the last result
    a_bare_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_last)
        else $error("bare marker without last");

    // no whitespace but a plain space, and no uppercase letter, leaves the block
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |->
            !((out_byte >= hnorm_pkg::CH_TAB) && (out_byte <= hnorm_pkg::CH_CR))
            && !hnorm_pkg::is_upper(out_byte))
        else $error("unnormalized byte");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid after reset");

endmodule

bind html_text_normalizer_top html_text_normalizer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .out_byte    (out_byte),
    .out_valid   (out_valid),
    .out_last    (out_last)
);

`default_nettype wire

### test/tb_html_text_normalizer_top.sv
`default_nettype none

module tb_html_text_normalizer_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]         b;
        logic               e;
        bit                 fixed;
        hnorm_pkg::result_t r0;
    } row_t;

    localparam hnorm_pkg::result_t NO_RES = '0;
    localparam int DIR_ROWS = 25;
    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_CYCLES = 300;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    logic [7:0] in_byte;
    logic       end_of_text;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    // normalizer state mirror
    hnorm_pkg::level_t  lvl;
    bit                 sp_seen;
    bit                 q_open;
    bit                 sp_held;
    bit                 last_eq;
    hnorm_pkg::result_t step_out [2];
    int                 n_out;

    hnorm_pkg::result_t norm_q [$];
    int                 errors;
    int                 items_sent;
    int                 send_idle;
    int                 recv_idle;
    bit                 stall_req;

    row_t dir_rows [DIR_ROWS] = '{
        '{8'h41, 1'b1, 1'b1, '{8'h61, 1'b1, 1'b1}},
        '{hnorm_pkg::CH_LT, 1'b0, 1'b1, '{hnorm_pkg::CH_LT, 1'b1, 1'b0}},
        '{hnorm_pkg::CH_SQ, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_SP, 1'b0, 1'b0, NO_RES},
        '{8'h42, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_TAB, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_EQ, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_CR, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_SQ, 1'b0, 1'b0, NO_RES},
        '{8'h78, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_SQ, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_SP, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_SQ, 1'b0, 1'b0, NO_RES},
        '{8'h0A, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_GT, 1'b0, 1'b0, NO_RES},
        '{8'h0B, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_GT, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_GT, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_UP_Z, 1'b0, 1'b0, NO_RES},
        '{hnorm_pkg::CH_EQ, 1'b0, 1'b0, NO_RES},
        '{8'h0C, 1'b1, 1'b0, NO_RES},
        '{hnorm_pkg::CH_LT, 1'b0, 1'b1, '{hnorm_pkg::CH_LT, 1'b1, 1'b0}},
        '{hnorm_pkg::CH_SP, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}
    };

    html_text_normalizer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .out_valid   (out_valid),
        .out_last    (out_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_state();
        lvl = '0;
        sp_seen = 1'b0;
        q_open = 1'b0;
        sp_held = 1'b0;
        last_eq = 1'b0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        if (n_out < 2)
        begin
            step_out[n_out] = '{b, 1'b1, 1'b0};
            n_out++;
            last_eq = (b == hnorm_pkg::CH_EQ);
        end
    endfunction

    function automatic void flush_held();
        if (sp_held)
        begin
            sp_held = 1'b0;
            emit_byte(hnorm_pkg::CH_SP);
        end
    endfunction

    function automatic void bump_level(input int d);
        int v;
        v = int'(lvl) + d;
        if (v > int'(hnorm_pkg::LEVEL_MAX))
            v = int'(hnorm_pkg::LEVEL_MAX);
        if (v < int'(hnorm_pkg::LEVEL_MIN))
            v = int'(hnorm_pkg::LEVEL_MIN);
        lvl = hnorm_pkg::level_t'(v);
    endfunction

    function automatic void normalize_byte(input logic [7:0] b, input logic e);
        logic [7:0] low;
        bit         conv;
        n_out = 0;
        if (b == hnorm_pkg::CH_LT)
        begin
            flush_held();
            emit_byte(hnorm_pkg::CH_LT);
            bump_level(1);
            if (lvl == hnorm_pkg::LEVEL_ONE)
                sp_seen = 1'b1;
        end
        else if (b == hnorm_pkg::CH_EQ && lvl == hnorm_pkg::LEVEL_ONE)
        begin
            sp_held = 1'b0;
            emit_byte(hnorm_pkg::CH_EQ);
            sp_seen = 1'b1;
        end
        else if (b == hnorm_pkg::CH_SP || (b >= hnorm_pkg::CH_TAB && b <= hnorm_pkg::CH_CR))
        begin
            if (!sp_seen)
            begin
                sp_held = 1'b1;
                sp_seen = 1'b1;
                last_eq = 1'b0;
            end
        end
        else if (b == hnorm_pkg::CH_GT)
        begin
            if (lvl == hnorm_pkg::LEVEL_ONE)
                sp_held = 1'b0;
            else
                flush_held();
            emit_byte(hnorm_pkg::CH_GT);
            bump_level(-1);
        end
        else if (b == hnorm_pkg::CH_SQ && lvl == hnorm_pkg::LEVEL_ONE)
        begin
            conv = q_open || (!sp_held && last_eq);
            flush_held();
            if (conv)
            begin
                emit_byte(hnorm_pkg::CH_DQ);
                q_open = !q_open;
            end
            else
                emit_byte(hnorm_pkg::CH_SQ);
        end
        else
        begin
            low = (b >= hnorm_pkg::CH_UP_A && b <= hnorm_pkg::CH_UP_Z)
                ? b + hnorm_pkg::CASE_OFS : b;
            flush_held();
            emit_byte(low);
            sp_seen = 1'b0;
        end
        if (e)
        begin
            flush_held();
            if (n_out == 0)
            begin
                step_out[0] = '{8'h00, 1'b0, 1'b1};
                n_out = 1;
            end
            else
                step_out[n_out-1].last = 1'b1;
            clear_state();
        end
    endfunction

    function automatic void queue_prediction();
        for (int k = 0; k < n_out; k++)
            norm_q.push_back(step_out[k]);
    endfunction

    // call at a rising edge; returns at the edge where the item is taken
    task automatic put_item(input logic [7:0] b, input logic e);
        bit taken;
        while ($urandom_range(0, 99) < send_idle)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte <= b;
        end_of_text <= e;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = byte_ready;
            @(posedge clk);
        end
        items_sent++;
        normalize_byte(b, e);
    endtask

    task automatic send(input logic [7:0] b, input logic e);
        put_item(b, e);
        queue_prediction();
    endtask

    task automatic feed(input logic [7:0] b);
        send(b, $urandom_range(0, 49) == 0);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        if ($urandom_range(0, 15) == 0)
            return 8'($urandom_range(128, 255));
        do
            c = 8'($urandom_range(33, 126));
        while (c == hnorm_pkg::CH_LT || c == hnorm_pkg::CH_GT
               || c == hnorm_pkg::CH_EQ || c == hnorm_pkg::CH_SQ);
        return c;
    endfunction

    function automatic logic [7:0] ws_char();
        logic [7:0] c;
        c = 8'($urandom_range(8, 13));
        return (c == 8'h08) ? hnorm_pkg::CH_SP : c;
    endfunction

    task automatic put_word();
        repeat ($urandom_range(1, 6)) feed(word_char());
    endtask

    task automatic put_ws(input int lo);
        repeat ($urandom_range(lo, 3)) feed(ws_char());
    endtask

    task automatic put_tag();
        feed(hnorm_pkg::CH_LT);
        put_ws(0);
        put_word();
        repeat ($urandom_range(0, 2))
        begin
            put_ws(1);
            put_word();
            put_ws(0);
            feed(hnorm_pkg::CH_EQ);
            put_ws(0);
            if ($urandom_range(0, 2) != 0)
            begin
                feed(hnorm_pkg::CH_SQ);
                put_word();
                if ($urandom_range(0, 1))
                begin
                    put_ws(1);
                    put_word();
                end
                feed(hnorm_pkg::CH_SQ);
            end
            else
                put_word();
        end
        if ($urandom_range(0, 7) == 0)
        begin
            feed(hnorm_pkg::CH_LT);
            put_word();
            feed(hnorm_pkg::CH_GT);
        end
        put_ws(0);
        feed(hnorm_pkg::CH_GT);
    endtask

    task automatic put_snippet();
        logic [7:0] stray [4];
        stray = '{hnorm_pkg::CH_LT, hnorm_pkg::CH_GT, hnorm_pkg::CH_EQ, hnorm_pkg::CH_SQ};
        case ($urandom_range(0, 9))
            0, 1, 2: put_word();
            3: put_ws(1);
            4, 5, 6, 7: put_tag();
            8: feed(8'($urandom_range(0, 255)));
            default: feed(stray[$urandom_range(0, 3)]);
        endcase
    endtask

    task automatic report(input bit stray, input hnorm_pkg::result_t want,
                          input hnorm_pkg::result_t got);
        errors++;
        if (errors <= 10)
        begin
            if (stray)
                $display("unexpected result: byte %02h valid %0b last %0b",
                         got.data, got.valid, got.last);
            else
                $display("mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                         want.data, want.valid, want.last, got.data, got.valid, got.last);
        end
    endtask

    // result side
    initial
    begin
        int                 hold;
        bit                 got;
        hnorm_pkg::result_t seen;
        hnorm_pkg::result_t want;
        hold = 0;
        got = 1'b0;
        seen = '0;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (got)
            begin
                if (norm_q.size() == 0)
                    report(1'b1, NO_RES, seen);
                else
                begin
                    want = norm_q.pop_front();
                    if (want !== seen)
                        report(1'b0, want, seen);
                end
            end
            if (stall_req)
            begin
                hold = HOLD_CYCLES;
                stall_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(0, 99) >= recv_idle);
            @(negedge clk);
            got = res_valid && res_ready;
            seen = '{out_byte, out_valid, out_last};
        end
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int start;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        in_byte = 8'h00;
        end_of_text = 1'b0;
        errors = 0;
        items_sent = 0;
        stall_req = 1'b0;
        send_idle = 26;
        recv_idle = 68;
        clear_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            put_item(dir_rows[i].b, dir_rows[i].e);
            if (dir_rows[i].fixed)
                norm_q.push_back(dir_rows[i].r0);
            else
                queue_prediction();
        end

        for (int p = 0; p < 3; p++)
        begin
            send_idle = (p == 0) ? 26 : (p == 1) ? 68 : 0;
            recv_idle = (p == 0) ? 68 : (p == 1) ? 26 : 0;
            if (p == 2)
                stall_req = 1'b1;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                put_snippet();
        end

        // depth lowered by three, then back up to one after an end marker
        repeat (3) send(hnorm_pkg::CH_GT, 1'b0);
        send(hnorm_pkg::CH_LT, 1'b0);
        send(hnorm_pkg::CH_SP, 1'b0);
        send(hnorm_pkg::CH_SQ, 1'b0);
        send(8'h51, 1'b0);
        send(hnorm_pkg::CH_GT, 1'b1);
        send(hnorm_pkg::CH_LT, 1'b0);
        send(hnorm_pkg::CH_EQ, 1'b0);
        send(hnorm_pkg::CH_TAB, 1'b1);
        byte_valid <= 1'b0;

        while (norm_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
